// ----- sv/rvex_pkg.sv -----
package rvex_pkg;

  localparam logic [3:0] CMD_LUI    = 4'd0;
  localparam logic [3:0] CMD_AUIPC  = 4'd1;
  localparam logic [3:0] CMD_JAL    = 4'd2;
  localparam logic [3:0] CMD_JALR   = 4'd3;
  localparam logic [3:0] CMD_BRANCH = 4'd4;
  localparam logic [3:0] CMD_LOAD   = 4'd5;
  localparam logic [3:0] CMD_STORE  = 4'd6;
  localparam logic [3:0] CMD_OPIMM  = 4'd7;
  localparam logic [3:0] CMD_OP     = 4'd8;

  localparam logic [2:0] F3_ADD  = 3'd0;
  localparam logic [2:0] F3_SLL  = 3'd1;
  localparam logic [2:0] F3_SLT  = 3'd2;
  localparam logic [2:0] F3_SLTU = 3'd3;
  localparam logic [2:0] F3_XOR  = 3'd4;
  localparam logic [2:0] F3_SR   = 3'd5;
  localparam logic [2:0] F3_OR   = 3'd6;
  localparam logic [2:0] F3_AND  = 3'd7;

  localparam logic [2:0] BR_EQ  = 3'd0;
  localparam logic [2:0] BR_NE  = 3'd1;
  localparam logic [2:0] BR_LT  = 3'd4;
  localparam logic [2:0] BR_GE  = 3'd5;
  localparam logic [2:0] BR_LTU = 3'd6;
  localparam logic [2:0] BR_GEU = 3'd7;

  localparam logic [2:0] MW_B  = 3'd0;
  localparam logic [2:0] MW_H  = 3'd1;
  localparam logic [2:0] MW_W  = 3'd2;
  localparam logic [2:0] MW_BU = 3'd4;
  localparam logic [2:0] MW_HU = 3'd5;

  localparam logic [1:0] MEM_NONE  = 2'd0;
  localparam logic [1:0] MEM_LOAD  = 2'd1;
  localparam logic [1:0] MEM_STORE = 2'd2;

  typedef struct packed {
    logic [3:0]  command;
    logic [2:0]  funct3;
    logic        alt_bit;
    logic [31:0] src1_value;
    logic [31:0] src2_value;
    logic [31:0] immediate;
    logic [5:0]  shift_amount;
    logic [4:0]  dest_index;
    logic [31:0] instr_pc;
  } exe_in_t;

  typedef struct packed {
    logic [31:0] write_value;
    logic        write_enable;
    logic [4:0]  write_index;
    logic [31:0] next_pc;
    logic [1:0]  mem_kind;
    logic [31:0] mem_address;
    logic [2:0]  mem_width;
    logic [31:0] store_data;
  } exe_out_t;

  typedef struct packed {
    logic [2:0] funct3;
    logic       sub_en;
    logic       sra_en;
  } alu_ctl_t;

endpackage

// ----- sv/rvex_alu.sv -----
module rvex_alu (
  input  rvex_pkg::alu_ctl_t ctl,
  input  logic [31:0]        a,
  input  logic [31:0]        b,
  output logic [31:0]        y
);
  import rvex_pkg::*;

  logic [4:0] shamt;

  assign shamt = b[4:0];

  always_comb begin
    case (ctl.funct3)
      F3_ADD:  y = ctl.sub_en ? (a - b) : (a + b);
      F3_SLL:  y = a << shamt;
      F3_SLT:  y = {31'd0, $signed(a) < $signed(b)};
      F3_SLTU: y = {31'd0, a < b};
      F3_XOR:  y = a ^ b;
      F3_SR:   y = ctl.sra_en ? 32'($signed(a) >>> shamt) : (a >> shamt);
      F3_OR:   y = a | b;
      F3_AND:  y = a & b;
      default: y = a & b;
    endcase
  end

endmodule

// ----- sv/rvex_exec.sv -----
module rvex_exec (
  input  rvex_pkg::exe_in_t  op,
  output rvex_pkg::exe_out_t res
);
  import rvex_pkg::*;

  logic [31:0] imm_i;
  logic [31:0] imm_b;
  logic [31:0] imm_j;
  logic [31:0] seq_pc;
  logic [31:0] pc_offset;
  logic [31:0] pc_target;
  logic [31:0] ea;
  logic [31:0] alu_b;
  logic [31:0] alu_y;
  alu_ctl_t    alu_ctl;
  logic        is_shift_imm;
  logic        taken;
  logic        we;
  logic [31:0] wval;

  assign imm_i  = {{20{op.immediate[11]}}, op.immediate[11:0]};
  assign imm_b  = {{19{op.immediate[12]}}, op.immediate[12:0]};
  assign imm_j  = {{11{op.immediate[20]}}, op.immediate[20:0]};
  assign seq_pc = op.instr_pc + 32'd4;
  assign ea     = op.src1_value + imm_i;

  assign is_shift_imm = (op.funct3 == F3_SLL) || (op.funct3 == F3_SR);

  always_comb begin
    case (op.command)
      CMD_JAL:    pc_offset = imm_j;
      CMD_BRANCH: pc_offset = imm_b;
      default:    pc_offset = op.immediate;
    endcase
  end

  assign pc_target = op.instr_pc + pc_offset;

  always_comb begin
    if (op.command == CMD_OP) begin
      alu_b = op.src2_value;
    end else if (is_shift_imm) begin
      alu_b = {27'd0, op.shift_amount[4:0]};
    end else begin
      alu_b = imm_i;
    end
    alu_ctl.funct3 = op.funct3;
    alu_ctl.sub_en = op.alt_bit && (op.command == CMD_OP);
    alu_ctl.sra_en = op.alt_bit;
  end

  rvex_alu u_alu (
    .ctl (alu_ctl),
    .a   (op.src1_value),
    .b   (alu_b),
    .y   (alu_y)
  );

  always_comb begin
    case (op.funct3)
      BR_EQ:   taken = op.src1_value == op.src2_value;
      BR_NE:   taken = op.src1_value != op.src2_value;
      BR_LT:   taken = $signed(op.src1_value) < $signed(op.src2_value);
      BR_GE:   taken = $signed(op.src1_value) >= $signed(op.src2_value);
      BR_LTU:  taken = op.src1_value < op.src2_value;
      BR_GEU:  taken = op.src1_value >= op.src2_value;
      default: taken = 1'b0;
    endcase
  end

  always_comb begin
    we              = 1'b0;
    wval            = alu_y;
    res.next_pc     = seq_pc;
    res.mem_kind    = MEM_NONE;
    res.mem_address = 32'd0;
    res.mem_width   = 3'd0;
    res.store_data  = 32'd0;
    case (op.command)
      CMD_LUI: begin
        we   = 1'b1;
        wval = op.immediate;
      end
      CMD_AUIPC: begin
        we   = 1'b1;
        wval = pc_target;
      end
      CMD_JAL: begin
        we          = 1'b1;
        wval        = seq_pc;
        res.next_pc = pc_target;
      end
      CMD_JALR: begin
        we          = 1'b1;
        wval        = seq_pc;
        res.next_pc = {ea[31:1], 1'b0};
      end
      CMD_BRANCH: begin
        if (taken) begin
          res.next_pc = pc_target;
        end
      end
      CMD_LOAD: begin
        if (op.funct3 == MW_B || op.funct3 == MW_H || op.funct3 == MW_W ||
            op.funct3 == MW_BU || op.funct3 == MW_HU) begin
          res.mem_kind    = MEM_LOAD;
          res.mem_width   = op.funct3;
          res.mem_address = ea;
        end
      end
      CMD_STORE: begin
        if (op.funct3 == MW_B || op.funct3 == MW_H || op.funct3 == MW_W) begin
          res.mem_kind    = MEM_STORE;
          res.mem_width   = op.funct3;
          res.mem_address = ea;
          res.store_data  = (op.funct3 == MW_B) ? {24'd0, op.src2_value[7:0]}
                                                : op.src2_value;
        end
      end
      CMD_OPIMM: begin
        we = !(is_shift_imm && op.shift_amount[5]);
      end
      CMD_OP: begin
        we = 1'b1;
      end
      default: begin
        we = 1'b0;
      end
    endcase
    res.write_index  = op.dest_index;
    res.write_enable = we && (op.dest_index != 5'd0);
    res.write_value  = res.write_enable ? wval : 32'd0;
  end

endmodule

// ----- sv/rv32i_execute_stage_core.sv -----
// An item accepted is held in the input register and its result is then loaded
// into the output register when the stage advances. Throughput: one item per
// cycle unless the output stalls; the whole execute path is one combinational
// pass between the two registers, bounded by one 32-bit add/compare.
// Reset (rst, synchronous): both stages empty; payload registers keep contents.
module rv32i_execute_stage_core (
  input  logic               clk,
  input  logic               rst,
  input  logic               issue_valid,
  output logic               issue_stall,
  input  rvex_pkg::exe_in_t  issue,
  output logic               result_valid,
  input  logic               result_stall,
  output rvex_pkg::exe_out_t result
);
  import rvex_pkg::*;

  exe_in_t  op;
  logic     op_valid;
  exe_out_t exec_res;
  logic     advance;
  logic     take;

  assign advance     = !result_valid || !result_stall;
  assign issue_stall = op_valid && !advance;
  assign take        = issue_valid && !issue_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      op_valid <= 1'b0;
    end else if (take) begin
      op_valid <= 1'b1;
    end else if (advance) begin
      op_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      op <= issue;
    end
  end

  rvex_exec u_exec (
    .op  (op),
    .res (exec_res)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if (advance) begin
      result_valid <= op_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      result <= exec_res;
    end
  end

  a_we_rd_nonzero: assert property (@(posedge clk) disable iff (rst)
    result_valid && result.write_enable |-> result.write_index != 5'd0)
    else $error("write enabled to x0");

  a_no_we_zero_value: assert property (@(posedge clk) disable iff (rst)
    result_valid && !result.write_enable |-> result.write_value == 32'd0)
    else $error("write value nonzero without write");

  a_mem_fields: assert property (@(posedge clk) disable iff (rst)
    result_valid && result.mem_kind == MEM_NONE |->
      result.mem_address == 32'd0 && result.mem_width == 3'd0 &&
      result.store_data == 32'd0)
    else $error("memory fields set without access");

  a_load_no_write: assert property (@(posedge clk) disable iff (rst)
    result_valid && result.mem_kind != MEM_NONE |-> !result.write_enable)
    else $error("memory access with register write");

  a_stage_moves: assert property (@(posedge clk) disable iff (rst)
    op_valid && advance |=> result_valid)
    else $error("held item lost between stages");

endmodule

// ----- dv/testbench.sv -----
module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  import rvex_pkg::*;

  localparam int RANDOM_ITEMS = 1400;
  localparam int CYCLE_LIMIT  = 100000;
  localparam int QUIET_FROM   = 800;
  localparam int QUIET_TO     = 1400;

  logic     clk = 1'b0;
  logic     rst = 1'b1;
  logic     issue_valid = 1'b0;
  logic     issue_stall;
  exe_in_t  issue = '0;
  logic     result_valid;
  logic     result_stall = 1'b0;
  exe_out_t result;

  exe_in_t  pending_q[$];
  exe_out_t expected_q[$];
  int       fail_count = 0;
  int       cycle_count = 0;
  bit       issue_taken = 1'b0;

  rv32i_execute_stage_core u_top (
    .clk(clk),
    .rst(rst),
    .issue_valid(issue_valid),
    .issue_stall(issue_stall),
    .issue(issue),
    .result_valid(result_valid),
    .result_stall(result_stall),
    .result(result)
  );

  initial begin
    forever #2 clk = ~clk;
  end

  function automatic logic [31:0] alu_eval(alu_ctl_t ctl, logic [31:0] a, logic [31:0] b);
    logic [4:0] sh;
    sh = b[4:0];
    case (ctl.funct3)
      F3_ADD:  return ctl.sub_en ? a - b : a + b;
      F3_SLL:  return a << sh;
      F3_SLT:  return {31'd0, $signed(a) < $signed(b)};
      F3_SLTU: return {31'd0, a < b};
      F3_XOR:  return a ^ b;
      F3_SR:   return ctl.sra_en ? $unsigned($signed(a) >>> sh) : a >> sh;
      F3_OR:   return a | b;
      default: return a & b;
    endcase
  endfunction

  function automatic exe_out_t execute_model(exe_in_t op);
    exe_out_t    r;
    alu_ctl_t    ctl;
    logic [31:0] a;
    logic [31:0] b;
    logic [31:0] imm12;
    logic [31:0] link;
    logic        taken;
    r = '0;
    a = op.src1_value;
    b = op.src2_value;
    imm12 = {{20{op.immediate[11]}}, op.immediate[11:0]};
    link = op.instr_pc + 32'd4;
    taken = 1'b0;
    r.write_index = op.dest_index;
    r.next_pc = link;
    case (op.command)
      CMD_LUI: begin
        r.write_value = op.immediate;
        r.write_enable = 1'b1;
      end
      CMD_AUIPC: begin
        r.write_value = op.instr_pc + op.immediate;
        r.write_enable = 1'b1;
      end
      CMD_JAL: begin
        r.write_value = link;
        r.write_enable = 1'b1;
        r.next_pc = op.instr_pc + {{11{op.immediate[20]}}, op.immediate[20:0]};
      end
      CMD_JALR: begin
        r.write_value = link;
        r.write_enable = 1'b1;
        r.next_pc = (a + imm12) & ~32'd1;
      end
      CMD_BRANCH: begin
        case (op.funct3)
          BR_EQ:   taken = (a == b);
          BR_NE:   taken = (a != b);
          BR_LT:   taken = ($signed(a) < $signed(b));
          BR_GE:   taken = ($signed(a) >= $signed(b));
          BR_LTU:  taken = (a < b);
          BR_GEU:  taken = (a >= b);
          default: taken = 1'b0;
        endcase
        if (taken) begin
          r.next_pc = op.instr_pc + {{19{op.immediate[12]}}, op.immediate[12:0]};
        end
      end
      CMD_LOAD: begin
        case (op.funct3)
          MW_B, MW_H, MW_W, MW_BU, MW_HU: begin
            r.mem_kind = MEM_LOAD;
            r.mem_width = op.funct3;
            r.mem_address = a + imm12;
          end
          default: ;
        endcase
      end
      CMD_STORE: begin
        case (op.funct3)
          MW_B, MW_H, MW_W: begin
            r.mem_kind = MEM_STORE;
            r.mem_width = op.funct3;
            r.mem_address = a + imm12;
            r.store_data = (op.funct3 == MW_B) ? {24'd0, b[7:0]} : b;
          end
          default: ;
        endcase
      end
      CMD_OPIMM: begin
        ctl.funct3 = op.funct3;
        ctl.sub_en = 1'b0;
        if (op.funct3 == F3_SLL || op.funct3 == F3_SR) begin
          ctl.sra_en = op.alt_bit;
          if (!op.shift_amount[5]) begin
            r.write_value = alu_eval(ctl, a, {27'd0, op.shift_amount[4:0]});
            r.write_enable = 1'b1;
          end
        end else begin
          ctl.sra_en = 1'b0;
          r.write_value = alu_eval(ctl, a, imm12);
          r.write_enable = 1'b1;
        end
      end
      CMD_OP: begin
        ctl.funct3 = op.funct3;
        ctl.sub_en = op.alt_bit;
        ctl.sra_en = op.alt_bit;
        r.write_value = alu_eval(ctl, a, b);
        r.write_enable = 1'b1;
      end
      default: ;
    endcase
    if (op.dest_index == 5'd0) begin
      r.write_enable = 1'b0;
    end
    if (!r.write_enable) begin
      r.write_value = '0;
    end
    return r;
  endfunction

  function automatic exe_in_t instr(logic [3:0] cmd, logic [2:0] f3, logic alt,
                                    logic [31:0] a, logic [31:0] b, logic [31:0] imm,
                                    logic [5:0] sh, logic [4:0] rd, logic [31:0] pc);
    exe_in_t op;
    op.command = cmd;
    op.funct3 = f3;
    op.alt_bit = alt;
    op.src1_value = a;
    op.src2_value = b;
    op.immediate = imm;
    op.shift_amount = sh;
    op.dest_index = rd;
    op.instr_pc = pc;
    return op;
  endfunction

  function automatic logic [31:0] pick_word();
    case ($urandom_range(0, 7))
      0:       return 32'h0000_0000;
      1:       return 32'hffff_ffff;
      2:       return 32'h8000_0000;
      3:       return 32'h7fff_ffff;
      4:       return $urandom_range(0, 15);
      default: return $urandom();
    endcase
  endfunction

  function automatic exe_in_t random_instr();
    exe_in_t     op;
    int unsigned pick;
    pick = $urandom_range(0, 99);
    if (pick < 92) begin
      op.command = 4'(pick % 9);
    end else begin
      op.command = 4'($urandom_range(9, 15));
    end
    op.funct3 = 3'($urandom_range(0, 7));
    op.alt_bit = 1'($urandom_range(0, 1));
    op.src1_value = pick_word();
    op.src2_value = ($urandom_range(0, 3) == 0) ? op.src1_value : pick_word();
    op.immediate = pick_word();
    op.shift_amount = 6'($urandom_range(0, 63));
    op.dest_index = 5'($urandom_range(0, 31));
    op.instr_pc = pick_word();
    return op;
  endfunction

  function automatic bit quiet_now();
    return cycle_count >= QUIET_FROM && cycle_count < QUIET_TO;
  endfunction

  task automatic check_field(string name, logic [31:0] exp, logic [31:0] act);
    if (exp !== act) begin
      $error("%s: expected %h, got %h", name, exp, act);
      fail_count++;
    end
  endtask

  // driver
  always @(negedge clk) begin
    if (rst) begin
      issue_valid <= 1'b0;
      result_stall <= 1'b0;
    end else begin
      if (!issue_valid || issue_taken) begin
        if (pending_q.size() > 0 && (quiet_now() || $urandom_range(0, 99) >= 15)) begin
          issue <= pending_q.pop_front();
          issue_valid <= 1'b1;
        end else begin
          issue_valid <= 1'b0;
        end
      end
      result_stall <= !quiet_now() && $urandom_range(0, 99) < 15;
    end
  end

  // monitor
  always @(posedge clk) begin
    exe_out_t exp;
    issue_taken = !rst && issue_valid && !issue_stall;
    if (issue_taken) begin
      expected_q.push_back(execute_model(issue));
    end
    if (!rst && result_valid && !result_stall) begin
      if (expected_q.size() == 0) begin
        $error("result item with none expected");
        fail_count++;
      end else begin
        exp = expected_q.pop_front();
        check_field("write_value", exp.write_value, result.write_value);
        check_field("write_enable", 32'(exp.write_enable), 32'(result.write_enable));
        check_field("write_index", 32'(exp.write_index), 32'(result.write_index));
        check_field("next_pc", exp.next_pc, result.next_pc);
        check_field("mem_kind", 32'(exp.mem_kind), 32'(result.mem_kind));
        check_field("mem_address", exp.mem_address, result.mem_address);
        check_field("mem_width", 32'(exp.mem_width), 32'(result.mem_width));
        check_field("store_data", exp.store_data, result.store_data);
      end
    end
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("** rv32i_execute_stage_core: FAILED **");
      $finish;
    end
  end

  initial begin
    pending_q.push_back(instr(CMD_LUI, 3'd0, 1'b0, 0, 0, 32'hffff_f000, 6'd0, 5'd31, 0));
    pending_q.push_back(instr(CMD_AUIPC, 3'd7, 1'b1, 0, 0, 32'h8000_0000, 6'd0, 5'd1,
                              32'hffff_fffc));
    pending_q.push_back(instr(CMD_JAL, 3'd0, 1'b0, 0, 0, 32'hfff0_0000, 6'd0, 5'd5,
                              32'h0000_0100));
    pending_q.push_back(instr(CMD_JALR, 3'd0, 1'b0, 32'hffff_ffff, 0, 32'h0000_0801,
                              6'd0, 5'd2, 32'hffff_fffc));
    pending_q.push_back(instr(CMD_BRANCH, BR_EQ, 1'b0, 32'h1234_5678, 32'h1234_5678,
                              32'h0000_1000, 6'd0, 5'd0, 32'h0000_2000));
    pending_q.push_back(instr(CMD_BRANCH, BR_NE, 1'b0, 0, 32'hffff_ffff, 32'h0000_0ffe,
                              6'd0, 5'd3, 32'h0000_0010));
    pending_q.push_back(instr(CMD_BRANCH, BR_LT, 1'b0, 32'h8000_0000, 0, 32'h0000_1ffe,
                              6'd0, 5'd0, 32'h8000_0000));
    pending_q.push_back(instr(CMD_BRANCH, BR_GE, 1'b0, 32'h7fff_ffff, 32'h8000_0000,
                              32'hffff_fff0, 6'd0, 5'd0, 32'h0000_0040));
    pending_q.push_back(instr(CMD_BRANCH, BR_LTU, 1'b0, 0, 32'hffff_ffff, 32'h0000_0008,
                              6'd0, 5'd0, 32'hffff_fff8));
    pending_q.push_back(instr(CMD_BRANCH, BR_GEU, 1'b0, 32'hffff_ffff, 32'hffff_ffff,
                              32'h0000_0004, 6'd0, 5'd0, 0));
    pending_q.push_back(instr(CMD_BRANCH, 3'd2, 1'b0, 0, 0, 32'h0000_0100, 6'd0, 5'd0,
                              32'h0000_0100));
    pending_q.push_back(instr(CMD_LOAD, MW_W, 1'b0, 32'h0000_1000, 0, 32'h0000_0fff,
                              6'd0, 5'd4, 0));
    pending_q.push_back(instr(CMD_LOAD, MW_HU, 1'b1, 32'hffff_ffff, 0, 32'h0000_07ff,
                              6'd0, 5'd31, 0));
    pending_q.push_back(instr(CMD_LOAD, 3'd3, 1'b0, 32'h0000_1000, 0, 32'h0000_0010,
                              6'd0, 5'd4, 0));
    pending_q.push_back(instr(CMD_STORE, MW_B, 1'b0, 32'h8000_0000, 32'hffff_ffff,
                              32'h0000_0800, 6'd0, 5'd7, 0));
    pending_q.push_back(instr(CMD_STORE, MW_W, 1'b0, 0, 32'hdead_beef, 32'hffff_ffff,
                              6'd0, 5'd0, 0));
    pending_q.push_back(instr(CMD_STORE, 3'd7, 1'b0, 0, 32'hdead_beef, 0, 6'd0, 5'd0, 0));
    pending_q.push_back(instr(CMD_OPIMM, F3_ADD, 1'b1, 32'h0000_0001, 0, 32'hffff_ffff,
                              6'd0, 5'd8, 0));
    pending_q.push_back(instr(CMD_OPIMM, F3_SR, 1'b1, 32'h8000_0000, 0, 0, 6'd31,
                              5'd9, 0));
    pending_q.push_back(instr(CMD_OPIMM, F3_SLL, 1'b0, 32'hffff_ffff, 0, 0, 6'd63,
                              5'd10, 0));
    pending_q.push_back(instr(CMD_OPIMM, F3_OR, 1'b1, 32'h0f0f_0000, 0, 32'h0000_00f0,
                              6'd0, 5'd11, 0));
    pending_q.push_back(instr(CMD_OP, F3_ADD, 1'b1, 0, 32'h0000_0001, 0, 6'd0, 5'd12, 0));
    pending_q.push_back(instr(CMD_OP, F3_SR, 1'b1, 32'h8000_0000, 32'h0000_003f, 0,
                              6'd0, 5'd13, 0));
    pending_q.push_back(instr(CMD_OP, F3_SLT, 1'b1, 32'h8000_0000, 32'h7fff_ffff, 0,
                              6'd0, 5'd0, 0));
    pending_q.push_back(instr(4'd15, 3'd7, 1'b1, 32'hffff_ffff, 32'hffff_ffff,
                              32'hffff_ffff, 6'd63, 5'd31, 32'hffff_ffff));
    for (int i = 0; i < RANDOM_ITEMS; i++) begin
      pending_q.push_back(random_instr());
    end

    repeat (11) @(negedge clk);
    rst <= 1'b0;

    while (pending_q.size() != 0 || issue_valid || expected_q.size() != 0) begin
      @(negedge clk);
    end
    repeat (8) @(negedge clk);
    if (fail_count == 0) begin
      $display("** rv32i_execute_stage_core: PASSED **");
    end else begin
      $display("** rv32i_execute_stage_core: FAILED **");
    end
    $finish;
  end

endmodule
